### rtl/core/der_evl_pkg.sv
// ----------------------------------------------------------------------------
// der_evl_pkg
// shared types and constants for the der extension value locator: channel
// payloads, control register indexes, der byte codes and parameter defaults
// ----------------------------------------------------------------------------
package der_evl_pkg;

   // parameter defaults
   localparam int MAX_PATTERN_BYTES_DEFAULT = 16;
   localparam int OFFSET_BITS_DEFAULT       = 16;

   // pattern register storage is fixed at 16 bytes
   localparam int PATTERN_STORE_BYTES = 16;

   // der byte codes
   localparam logic [7:0] TAG_BOOLEAN      = 8'h01;
   localparam logic [7:0] BOOLEAN_LENGTH   = 8'h01;
   localparam logic [7:0] BOOLEAN_FALSE    = 8'h00;
   localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
   localparam logic [7:0] LENGTH_LONG_TWO  = 8'h82;

   localparam logic [15:0] MIN_VALUE_SIZE     = 16'd128;
   localparam logic [15:0] MAX_VALUE_SIZE_RST = 16'd8192;
   localparam logic [4:0]  PATTERN_LENGTH_RST = 5'd1;

   // control register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN_LOW_BYTES  = 2'd0,
      CSR_PATTERN_HIGH_BYTES = 2'd1,
      CSR_PATTERN_LENGTH     = 2'd2,
      CSR_MAX_VALUE_SIZE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        status;
      logic [15:0] value_offset;
      logic [15:0] value_size;
   } rsp_payload_type;

endpackage

### rtl/core/der_extension_value_locator.sv
// ----------------------------------------------------------------------------
// der_extension_value_locator
// scans an extension area byte stream for an identifier pattern and locates
// the octet string value that follows it
// ----------------------------------------------------------------------------
// usage
//  - req channel: one byte of the extension area per transfer, last_byte
//    marks the final byte of a stream
//  - rsp channel: exactly one result per stream, produced by the transfer
//    that carries last_byte; other bytes produce nothing
//  - csr channel: pattern bytes, pattern length and maximum value size;
//    csr_ready is always high, writes belong between streams
//  - throughput: one byte per cycle while req_stall is low; pattern compare,
//    phase update and the final checks all finish in the cycle the byte is taken
//  - result: held in the rsp output register from the cycle after the last
//    byte is transferred
//  - stall: while a result sits in the output register and rsp_stall is high,
//    req_stall is raised so no new last byte can overwrite it
//  - reset (synchronous, active high): stream state clears, the registers
//    return to pattern length 1, max size 8192, pattern bytes zero;
//    req_stall stays high while reset is asserted
//  - after each result all stream state returns to its reset value
// ----------------------------------------------------------------------------
module der_extension_value_locator #(
   parameter int MAX_PATTERN_BYTES = der_evl_pkg::MAX_PATTERN_BYTES_DEFAULT,
   parameter int OFFSET_BITS       = der_evl_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  der_evl_pkg::req_payload_type    req_payload,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output der_evl_pkg::rsp_payload_type    rsp_payload,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  der_evl_pkg::csr_index_type      csr_index,
   input  logic [63:0]                     csr_wdata
);
   import der_evl_pkg::*;

   localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int WIN_W     = 8 * MAX_PATTERN_BYTES;
   localparam int OFF_EXT_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

   typedef enum logic [3:0] {
      PH_SEARCH,
      PH_AFTER_ID,
      PH_BOOL_LEN,
      PH_BOOL_VAL,
      PH_TAG,
      PH_LEN_FORM,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_VALUE,
      PH_FAILED
   } phase_type;

   // configuration registers
   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [4:0]  pattern_length_ff;
   logic [15:0] max_value_size_ff;

   // stream state
   logic [MAX_PATTERN_BYTES-1:0][7:0] window_ff, window_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [OFFSET_BITS-1:0]            position_ff, position_in;
   phase_type                         phase_ff, phase_in;
   logic [15:0]                       length_ff, length_in;
   logic [OFFSET_BITS-1:0]            start_ff, start_in;
   logic [15:0]                       seen_ff, seen_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                                req_fire;
   logic [WIN_W+7:0]                    shift_wide;
   logic [MAX_PATTERN_BYTES-1:0][7:0]   window_shift;
   logic [FILL_W-1:0]                   fill_shift;
   logic [FILL_W-1:0]                   len_eff;
   logic [PATTERN_STORE_BYTES-1:0][7:0] pattern_bytes;
   logic                                pattern_hit;
   logic [IDX_W-1:0]                    sel_idx;
   logic                                result_ok;
   logic [7:0]                          data_byte;
   logic [OFF_EXT_W-1:0]                start_ext;

   // ---------------------------------------------------------------- handshakes
   // hold off bytes while a result waits on a stalled receiver
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign req_fire  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign data_byte     = req_payload.data_byte;
   assign pattern_bytes = {pattern_high_ff, pattern_low_ff};

   // ---------------------------------------------------------------- pattern compare
   // newest byte lands in window byte 0
   assign shift_wide   = {window_ff, data_byte};
   assign window_shift = shift_wide[WIN_W-1:0];
   assign fill_shift   = (fill_ff < FILL_W'(MAX_PATTERN_BYTES)) ? fill_ff + 1'b1 : fill_ff;

   // pattern length zero acts as one byte, anything past the bound as the bound
   always_comb begin
      if (pattern_length_ff == 5'd0) begin
         len_eff = FILL_W'(1);
      end else if (pattern_length_ff > 5'(MAX_PATTERN_BYTES)) begin
         len_eff = FILL_W'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = FILL_W'(pattern_length_ff);
      end
   end

   // pattern byte i sits at window byte len-1-i
   always_comb begin
      pattern_hit = (fill_shift >= len_eff);
      sel_idx     = '0;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         sel_idx = IDX_W'(int'(len_eff) - 1 - i);
         if (i < int'(len_eff)) begin
            if (pattern_bytes[i] != window_shift[sel_idx]) begin
               pattern_hit = 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stream update
   always_comb begin
      window_in   = window_ff;
      fill_in     = fill_ff;
      position_in = position_ff;
      phase_in    = phase_ff;
      length_in   = length_ff;
      start_in    = start_ff;
      seen_in     = seen_ff;
      result_ok   = 1'b0;

      if (req_fire) begin
         // byte offset saturates at the top of its range
         if (position_ff != '1) begin
            position_in = position_ff + 1'b1;
         end

         case (phase_ff)
            PH_SEARCH: begin
               window_in = window_shift;
               fill_in   = fill_shift;
               if (pattern_hit) begin
                  phase_in = PH_AFTER_ID;
               end
            end
            PH_AFTER_ID: begin
               // optional criticality boolean, or straight to the octet string
               if (data_byte == TAG_BOOLEAN) begin
                  phase_in = PH_BOOL_LEN;
               end else if (data_byte == TAG_OCTET_STRING) begin
                  phase_in = PH_LEN_FORM;
               end else begin
                  phase_in = PH_FAILED;
               end
            end
            PH_BOOL_LEN: begin
               phase_in = (data_byte == BOOLEAN_LENGTH) ? PH_BOOL_VAL : PH_FAILED;
            end
            PH_BOOL_VAL: begin
               phase_in = (data_byte == BOOLEAN_FALSE) ? PH_TAG : PH_FAILED;
            end
            PH_TAG: begin
               phase_in = (data_byte == TAG_OCTET_STRING) ? PH_LEN_FORM : PH_FAILED;
            end
            PH_LEN_FORM: begin
               phase_in = (data_byte == LENGTH_LONG_TWO) ? PH_LEN_HI : PH_FAILED;
            end
            PH_LEN_HI: begin
               length_in = {data_byte, 8'h00};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = length_ff | {8'h00, data_byte};
               start_in  = position_in;
               seen_in   = '0;
               phase_in  = PH_VALUE;
            end
            PH_VALUE: begin
               if (seen_ff != '1) begin
                  seen_in = seen_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_FAILED;
            end
         endcase

         // final checks use the state after this byte
         result_ok = (phase_in == PH_VALUE)
                     && (length_in >= MIN_VALUE_SIZE)
                     && (length_in <= max_value_size_ff)
                     && (length_in <= seen_in);

         // end of stream: back to a fresh search
         if (req_payload.last_byte) begin
            window_in   = '0;
            fill_in     = '0;
            position_in = '0;
            phase_in    = PH_SEARCH;
            length_in   = '0;
            start_in    = '0;
            seen_in     = '0;
         end
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      start_ext = OFF_EXT_W'(start_ff);
      if (req_fire && req_payload.last_byte) begin
         // start_ff is not yet updated when the length ends on the last byte
         start_ext                 = (phase_ff == PH_LEN_LO) ?
                                     OFF_EXT_W'(position_ff == '1 ? position_ff :
                                                position_ff + 1'b1) :
                                     OFF_EXT_W'(start_ff);
         rsp_valid_in              = 1'b1;
         rsp_payload_in.status     = ~result_ok;
         rsp_payload_in.value_offset = result_ok ? start_ext[15:0] : 16'd0;
         rsp_payload_in.value_size = result_ok ?
                                     ((phase_ff == PH_LEN_LO) ?
                                      (length_ff | {8'h00, data_byte}) : length_ff) :
                                     16'd0;
      end else begin
         rsp_valid_in   = rsp_valid_ff & rsp_stall;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= PATTERN_LENGTH_RST;
         max_value_size_ff <= MAX_VALUE_SIZE_RST;
         window_ff         <= '0;
         fill_ff           <= '0;
         position_ff       <= '0;
         phase_ff          <= PH_SEARCH;
         length_ff         <= '0;
         start_ff          <= '0;
         seen_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_PATTERN_LOW_BYTES:  pattern_low_ff    <= csr_wdata;
               CSR_PATTERN_HIGH_BYTES: pattern_high_ff   <= csr_wdata;
               CSR_PATTERN_LENGTH:     pattern_length_ff <= csr_wdata[4:0];
               CSR_MAX_VALUE_SIZE:     max_value_size_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         position_ff  <= position_in;
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         start_ff     <= start_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   // ---------------------------------------------------------------- assertions
`ifndef NO_ASSERTIONS
   // a result appears only after a last byte was taken
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && req_payload.last_byte))
      else $error("result without a last byte");

   // a byte that is not last never produces a result
   a_no_rsp_mid_stream: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_payload.last_byte |=> !rsp_valid_ff)
      else $error("result from a byte that is not last");

   // every stream end leaves a fresh search
   a_stream_cleared: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.last_byte |=> phase_ff == PH_SEARCH && fill_ff == '0
                                           && position_ff == '0)
      else $error("stream state not cleared after last byte");

   // an ok result respects the size limits
   a_ok_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.status |->
         rsp_payload_ff.value_size >= MIN_VALUE_SIZE
         && rsp_payload_ff.value_size <= max_value_size_ff)
      else $error("ok result with size out of range");

   // a failed result carries zero offset and size
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.status |->
         rsp_payload_ff.value_offset == 16'd0 && rsp_payload_ff.value_size == 16'd0)
      else $error("failed result with nonzero fields");
`endif

endmodule

### bench/der_evl_checker.sv
// ----------------------------------------------------------------------------
// der_evl_checker
// follows the byte, result and register transfers of the der extension value
// locator, works out the result of every stream on its own and compares the
// results that come out field by field, oldest first
// ----------------------------------------------------------------------------
module der_evl_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  der_evl_pkg::req_payload_type req_payload,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  der_evl_pkg::rsp_payload_type rsp_payload,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  der_evl_pkg::csr_index_type   csr_index,
   input  logic [63:0]                  csr_wdata,
   output int unsigned                  mismatch_count,
   output int unsigned                  results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import der_evl_pkg::*;

   localparam int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEFAULT;
   localparam int unsigned POSITION_LIMIT    = (1 << OFFSET_BITS_DEFAULT) - 1;

   typedef enum logic [3:0] {
      SEEK_PATTERN,
      AFTER_PATTERN,
      BOOLEAN_LENGTH_BYTE,
      BOOLEAN_VALUE_BYTE,
      OCTET_TAG,
      LENGTH_FORM,
      LENGTH_HIGH,
      LENGTH_LOW,
      VALUE_BYTES,
      GAVE_UP
   } scan_phase_type;

   // register copies
   logic [63:0] pattern_low;
   logic [63:0] pattern_high;
   logic [4:0]  pattern_len;
   logic [15:0] max_size;

   // stream state
   logic [127:0]   window;
   int unsigned    window_fill;
   int unsigned    position;
   scan_phase_type phase;
   logic [15:0]    value_length;
   int unsigned    value_start;
   int unsigned    value_seen;

   rsp_payload_type located_results[$];
   int unsigned     mismatches;
   int unsigned     results_checked;

   function automatic logic window_holds_pattern();
      int unsigned  span;
      logic [127:0] pattern;
      span = (pattern_len == 0) ? 1 :
             (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pattern_len;
      pattern = {pattern_high, pattern_low};
      if (window_fill < span) return 1'b0;
      // pattern byte 0 is the oldest of the newest span bytes
      for (int i = 0; i < span; i++)
         if (pattern[8*i +: 8] != window[8*(span-1-i) +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic clear_stream();
      window       = '0;
      window_fill  = 0;
      position     = 0;
      phase        = SEEK_PATTERN;
      value_length = '0;
      value_start  = 0;
      value_seen   = 0;
   endtask

   task automatic take_byte(input req_payload_type item);
      rsp_payload_type want;
      logic            located;
      if (position < POSITION_LIMIT) position++;
      case (phase)
         SEEK_PATTERN: begin
            window = {window[119:0], item.data_byte};
            if (window_fill < MAX_PATTERN_BYTES) window_fill++;
            if (window_holds_pattern()) phase = AFTER_PATTERN;
         end
         AFTER_PATTERN: begin
            if (item.data_byte == TAG_BOOLEAN) phase = BOOLEAN_LENGTH_BYTE;
            else if (item.data_byte == TAG_OCTET_STRING) phase = LENGTH_FORM;
            else phase = GAVE_UP;
         end
         BOOLEAN_LENGTH_BYTE: begin
            if (item.data_byte == BOOLEAN_LENGTH) phase = BOOLEAN_VALUE_BYTE;
            else phase = GAVE_UP;
         end
         BOOLEAN_VALUE_BYTE: begin
            if (item.data_byte == BOOLEAN_FALSE) phase = OCTET_TAG;
            else phase = GAVE_UP;
         end
         OCTET_TAG: begin
            if (item.data_byte == TAG_OCTET_STRING) phase = LENGTH_FORM;
            else phase = GAVE_UP;
         end
         LENGTH_FORM: begin
            if (item.data_byte == LENGTH_LONG_TWO) phase = LENGTH_HIGH;
            else phase = GAVE_UP;
         end
         LENGTH_HIGH: begin
            value_length = {item.data_byte, 8'h00};
            phase        = LENGTH_LOW;
         end
         LENGTH_LOW: begin
            value_length[7:0] = item.data_byte;
            value_start       = position;
            value_seen        = 0;
            phase             = VALUE_BYTES;
         end
         VALUE_BYTES: begin
            if (value_seen < 32'hFFFF) value_seen++;
         end
         default: phase = GAVE_UP;
      endcase
      if (item.last_byte) begin
         located = phase == VALUE_BYTES && value_length >= MIN_VALUE_SIZE
                   && value_length <= max_size && value_length <= value_seen;
         want.status       = !located;
         want.value_offset = located ? 16'(value_start) : '0;
         want.value_size   = located ? value_length : '0;
         located_results.push_back(want);
         clear_stream();
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("%0t: result %0d: %s", $time, results_checked, what);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         pattern_low  = '0;
         pattern_high = '0;
         pattern_len  = PATTERN_LENGTH_RST;
         max_size     = MAX_VALUE_SIZE_RST;
         clear_stream();
         located_results.delete();
         mismatches      = 0;
         results_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW_BYTES:  pattern_low  = csr_wdata;
               CSR_PATTERN_HIGH_BYTES: pattern_high = csr_wdata;
               CSR_PATTERN_LENGTH:     pattern_len  = csr_wdata[4:0];
               CSR_MAX_VALUE_SIZE:     max_size     = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) take_byte(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (located_results.size() == 0) begin
               flag_mismatch("result transfer with nothing expected");
            end else begin
               want = located_results.pop_front();
               if (rsp_payload.status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_payload.status, want.status));
               if (rsp_payload.value_offset !== want.value_offset)
                  flag_mismatch($sformatf("value_offset %0d, expected %0d",
                                          rsp_payload.value_offset, want.value_offset));
               if (rsp_payload.value_size !== want.value_size)
                  flag_mismatch($sformatf("value_size %0d, expected %0d",
                                          rsp_payload.value_size, want.value_size));
            end
            results_checked++;
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= located_results.size();
   end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives byte streams of certificate extension areas into the der extension
// value locator under random idling on both channels, reprograms pattern,
// pattern length and maximum value size between phases, and reports the
// verdict of the checker that sits beside the block
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import der_evl_pkg::*;

   localparam int unsigned QUIET_LIMIT   = 2000;   // cycles without any transfer
   localparam int unsigned BYTE_TARGET   = 1100;
   localparam int unsigned STREAM_TARGET = 12;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid   = 1'b0;
   logic            csr_ready;
   csr_index_type   csr_index   = CSR_PATTERN_LOW_BYTES;
   logic [63:0]     csr_wdata   = '0;

   int unsigned mismatch_count;
   int unsigned results_pending;

   // stimulus-side view of the registers, only used to build streams
   logic [127:0] pattern_now = '0;
   int unsigned  span_now    = 1;
   logic [15:0]  max_now     = MAX_VALUE_SIZE_RST;

   // idling control
   logic        tail_calm   = 1'b0;  // last part of the run: no idling at all
   int unsigned calm_left   = 0;     // sender stretch with no gaps
   int unsigned hold_left   = 0;     // receiver stall burst still to go
   int unsigned free_left   = 0;     // receiver stretch with no stall

   int unsigned bytes_sent   = 0;
   int unsigned streams_sent = 0;
   int unsigned idle_cycles  = 0;
   logic [7:0]  stream_q[$];

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   der_extension_value_locator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   der_evl_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // watchdog: any transfer on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side backpressure: random stall bursts between free stretches,
   // some of them long
   always @(posedge clock) begin
      if (tail_calm) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (free_left != 0) begin
         rsp_stall <= 1'b0;
         free_left <= free_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
         free_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
      end
   end

   // one byte transfer, maybe after a gap; valid stays high afterwards so
   // the next byte can follow back to back
   task automatic send_byte(input logic [7:0] value, input logic end_mark);
      if (!tail_calm) begin
         if (calm_left != 0) begin
            calm_left--;
         end else if ($urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else if ($urandom_range(0, 40) == 0) begin
            calm_left = $urandom_range(50, 200);
         end
      end
      req_payload <= '{data_byte: value, last_byte: end_mark};
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // the whole queue as one stream, last byte marked
   task automatic send_stream();
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      streams_sent++;
   endtask

   // hold off the sender until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      // a little margin after the last result
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type which, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // all four registers, written only once the block is idle; unused upper
   // bits of the narrow registers carry noise
   task automatic apply_setting(input logic [127:0] pattern, input logic [4:0] span_code,
                                input logic [15:0] size_cap);
      logic [63:0] word;
      wait_drained();
      write_register(CSR_PATTERN_LOW_BYTES, pattern[63:0]);
      write_register(CSR_PATTERN_HIGH_BYTES, pattern[127:64]);
      word = {$urandom, $urandom};
      word[4:0] = span_code;
      write_register(CSR_PATTERN_LENGTH, word);
      word = {$urandom, $urandom};
      word[15:0] = size_cap;
      write_register(CSR_MAX_VALUE_SIZE, word);
      csr_valid <= 1'b0;
      pattern_now = pattern;
      // zero acts as one byte, anything past 16 as 16
      span_now = (span_code == 0) ? 1 : (span_code > 16) ? 16 : span_code;
      max_now  = size_cap;
   endtask

   task automatic append_pattern();
      for (int i = 0; i < span_now; i++) stream_q.push_back(pattern_now[8*i +: 8]);
   endtask

   task automatic append_header(input logic with_boolean);
      if (with_boolean) begin
         stream_q.push_back(TAG_BOOLEAN);
         stream_q.push_back(BOOLEAN_LENGTH);
         stream_q.push_back(BOOLEAN_FALSE);
      end
      stream_q.push_back(TAG_OCTET_STRING);
      stream_q.push_back(LENGTH_LONG_TWO);
   endtask

   // one random stream; half are well formed with value bytes near the size,
   // the rest corrupt, cut short, repeat the pattern after a failure or are noise
   task automatic random_stream();
      int unsigned kind;
      int unsigned lead;
      int unsigned cut;
      int          count;
      logic [15:0] size;
      stream_q.delete();
      lead = $urandom_range(0, 6);
      repeat (lead) stream_q.push_back(8'($urandom));
      kind = $urandom_range(0, 9);
      // value size biased to the acceptance edges
      case ($urandom_range(0, 7))
         0: size = MIN_VALUE_SIZE - 16'd1;
         1: size = MIN_VALUE_SIZE;
         2: size = MIN_VALUE_SIZE + 16'd1;
         3: size = max_now;
         4: size = max_now + 16'd1;
         5: size = MIN_VALUE_SIZE + 16'($urandom_range(0, 100));
         6: size = 16'($urandom);
         default: size = 16'hFFFF;
      endcase
      if (kind == 8) begin
         repeat ($urandom_range(1, 20)) stream_q.push_back(8'($urandom));
      end else begin
         append_pattern();
         if (kind == 9) begin
            // bad tag right after the first match, then a clean header that
            // must not count any more
            stream_q.push_back(8'($urandom_range(5, 255)));
            append_pattern();
         end
         append_header($urandom_range(0, 1));
         stream_q.push_back(size[15:8]);
         stream_q.push_back(size[7:0]);
         if (kind <= 4) begin
            // up to size 400: value bytes one short of the size to two past it, else 0 to 16
            if (size <= 400) count = int'(size) + int'($urandom_range(0, 3)) - 1;
            else count = $urandom_range(0, 16);
            if (count < 0) count = 0;
            repeat (count) stream_q.push_back(8'($urandom));
         end else if (kind <= 6) begin
            // flip bits in one pattern, header or length byte
            cut = $urandom_range(lead, stream_q.size() - 1);
            stream_q[cut] ^= 8'($urandom_range(1, 255));
            repeat ($urandom_range(0, 8)) stream_q.push_back(8'($urandom));
         end else if (kind == 7) begin
            // end somewhere in the pattern, header or length, match on the last byte too
            cut = $urandom_range(lead + 1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end else begin
            repeat (4) stream_q.push_back(8'($urandom));
         end
      end
      send_stream();
   endtask

   initial begin
      logic [4:0]  span_code;
      logic [15:0] size_cap;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings: single pattern byte 00
      stream_q = '{8'hFF};                  // no match at all
      send_stream();
      stream_q = '{8'h00};                  // match on the last byte
      send_stream();
      // boolean skipped, length read on the last byte, nothing after it
      stream_q = '{8'h00, TAG_BOOLEAN, BOOLEAN_LENGTH, BOOLEAN_FALSE,
                   TAG_OCTET_STRING, LENGTH_LONG_TWO, 8'hFF, 8'hFF};
      send_stream();
      stream_q = '{8'h00, 8'h05};           // wrong tag after the match
      send_stream();
      stream_q = '{8'h00, TAG_OCTET_STRING, 8'h81};  // wrong length form
      send_stream();
      stream_q = '{8'h7F, 8'h00, TAG_BOOLEAN, 8'h02};  // wrong boolean length
      send_stream();
      // pattern length zero behaves as one byte
      apply_setting(128'hA5, 5'd0, MAX_VALUE_SIZE_RST);
      stream_q = '{8'hA5, TAG_OCTET_STRING};
      send_stream();

      // random part: a fresh setting per phase, extremes included
      while (bytes_sent < BYTE_TARGET || streams_sent < STREAM_TARGET) begin
         case ($urandom_range(0, 9))
            0: span_code = 5'd0;
            1: span_code = 5'd1;
            2: span_code = 5'd16;
            3: span_code = 5'($urandom_range(17, 31));
            default: span_code = 5'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 7))
            0: size_cap = 16'd0;
            1: size_cap = MIN_VALUE_SIZE - 16'd1;
            2: size_cap = MIN_VALUE_SIZE;
            3: size_cap = MIN_VALUE_SIZE + 16'd1;
            4: size_cap = 16'($urandom_range(130, 300));
            5: size_cap = MAX_VALUE_SIZE_RST;
            6: size_cap = 16'hFFFF;
            default: size_cap = 16'($urandom);
         endcase
         apply_setting({$urandom, $urandom, $urandom, $urandom}, span_code, size_cap);
         repeat ($urandom_range(3, 10)) begin
            if (bytes_sent >= BYTE_TARGET && streams_sent >= STREAM_TARGET) break;
            // now and then let every result come back before going on
            if ($urandom_range(0, 15) == 0) wait_drained();
            random_stream();
         end
      end

      // tail: no idling on either side
      tail_calm <= 1'b1;
      repeat (5) random_stream();

      wait_drained();
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
